// ----- hw/rtl/mdeu_pkg.sv -----
// Package for the MIPS decode and execute unit: transaction payload types,
// opcode, function and memory access codes. No dependencies.
package mdeu_pkg;

  typedef struct packed {
    logic [31:0]        instr_word;
    logic signed [31:0] rs_value;
    logic signed [31:0] rt_value;
    logic [31:0]        pc;
  } in_t;

  typedef struct packed {
    logic signed [31:0] exec_value;
    logic               reg_write;
    logic [4:0]         write_reg;
    logic [3:0]         mem_kind;
    logic signed [31:0] store_data;
    logic               take_branch;
    logic [31:0]        branch_target;
    logic               halt;
  } out_t;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_BGTZ  = 6'd7;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_NORI  = 6'd14;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LB    = 6'd32;
  localparam logic [5:0] OP_LH    = 6'd33;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_LBU   = 6'd36;
  localparam logic [5:0] OP_LHU   = 6'd37;
  localparam logic [5:0] OP_SB    = 6'd40;
  localparam logic [5:0] OP_SH    = 6'd41;
  localparam logic [5:0] OP_SW    = 6'd43;
  localparam logic [5:0] OP_HALT  = 6'd63;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_NAND = 6'd40;
  localparam logic [5:0] FN_SLT  = 6'd42;

  localparam logic [3:0] MK_NONE = 4'd0;
  localparam logic [3:0] MK_LW   = 4'd1;
  localparam logic [3:0] MK_LH   = 4'd2;
  localparam logic [3:0] MK_LHU  = 4'd3;
  localparam logic [3:0] MK_LB   = 4'd4;
  localparam logic [3:0] MK_LBU  = 4'd5;
  localparam logic [3:0] MK_SW   = 4'd6;
  localparam logic [3:0] MK_SH   = 4'd7;
  localparam logic [3:0] MK_SB   = 4'd8;

  localparam logic [4:0] LINK_REG = 5'd31;

endpackage

// ----- hw/rtl/mdeu_core.sv -----
// Combinational decode and execute of one instruction transaction.
// Depends on mdeu_pkg for payload types and instruction codes.
module mdeu_core (
  input  mdeu_pkg::in_t  op_in,
  output mdeu_pkg::out_t res_out
);
  import mdeu_pkg::*;

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [15:0] imm;
  logic [31:0] zimm;
  logic [31:0] simm;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] pc4;
  logic [31:0] btgt;
  logic [31:0] jtgt;
  logic [31:0] addr;

  assign opc  = op_in.instr_word[31:26];
  assign rt   = op_in.instr_word[20:16];
  assign rd   = op_in.instr_word[15:11];
  assign sh   = op_in.instr_word[10:6];
  assign fn   = op_in.instr_word[5:0];
  assign imm  = op_in.instr_word[15:0];
  assign zimm = {16'd0, imm};
  assign simm = {{16{imm[15]}}, imm};
  assign a    = op_in.rs_value;
  assign b    = op_in.rt_value;
  assign pc4  = op_in.pc + 32'd4;
  assign btgt = pc4 + {simm[29:0], 2'b00};
  assign jtgt = {pc4[31:28], op_in.instr_word[25:0], 2'b00};
  assign addr = a + simm;

  always_comb begin
    res_out = '0;
    case (opc)
      OP_RTYPE: begin
        res_out.reg_write = 1'b1;
        res_out.write_reg = rd;
        case (fn)
          FN_ADD, FN_ADDU: res_out.exec_value = a + b;
          FN_SUB:  res_out.exec_value = a - b;
          FN_AND:  res_out.exec_value = a & b;
          FN_OR:   res_out.exec_value = a | b;
          FN_XOR:  res_out.exec_value = a ^ b;
          FN_NOR:  res_out.exec_value = ~(a | b);
          FN_NAND: res_out.exec_value = ~(a & b);
          FN_SLT:  res_out.exec_value = {31'd0, op_in.rs_value < op_in.rt_value};
          FN_SLL:  res_out.exec_value = b << sh;
          FN_SRL:  res_out.exec_value = b >> sh;
          FN_SRA:  res_out.exec_value = op_in.rt_value >>> sh;
          FN_JR: begin
            res_out.reg_write     = 1'b0;
            res_out.write_reg     = '0;
            res_out.take_branch   = 1'b1;
            res_out.branch_target = a;
          end
          default: begin
            res_out.reg_write = 1'b0;
            res_out.write_reg = '0;
          end
        endcase
      end
      OP_ADDI, OP_ADDIU: begin
        res_out.exec_value = addr;
        res_out.reg_write  = 1'b1;
        res_out.write_reg  = rt;
      end
      OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU: begin
        res_out.exec_value = addr;
        res_out.reg_write  = 1'b1;
        res_out.write_reg  = rt;
        case (opc)
          OP_LW:   res_out.mem_kind = MK_LW;
          OP_LH:   res_out.mem_kind = MK_LH;
          OP_LHU:  res_out.mem_kind = MK_LHU;
          OP_LB:   res_out.mem_kind = MK_LB;
          default: res_out.mem_kind = MK_LBU;
        endcase
      end
      OP_SW, OP_SH, OP_SB: begin
        res_out.exec_value = addr;
        res_out.store_data = op_in.rt_value;
        case (opc)
          OP_SW:   res_out.mem_kind = MK_SW;
          OP_SH:   res_out.mem_kind = MK_SH;
          default: res_out.mem_kind = MK_SB;
        endcase
      end
      OP_LUI: begin
        res_out.exec_value = {imm, 16'd0};
        res_out.reg_write  = 1'b1;
        res_out.write_reg  = rt;
      end
      OP_ANDI: begin
        res_out.exec_value = a & zimm;
        res_out.reg_write  = 1'b1;
        res_out.write_reg  = rt;
      end
      OP_ORI: begin
        res_out.exec_value = a | zimm;
        res_out.reg_write  = 1'b1;
        res_out.write_reg  = rt;
      end
      OP_NORI: begin
        res_out.exec_value = ~(a | zimm);
        res_out.reg_write  = 1'b1;
        res_out.write_reg  = rt;
      end
      OP_SLTI: begin
        res_out.exec_value = {31'd0, op_in.rs_value < $signed(simm)};
        res_out.reg_write  = 1'b1;
        res_out.write_reg  = rt;
      end
      OP_HALT: res_out.halt = 1'b1;
      OP_BEQ: begin
        res_out.take_branch   = (a == b);
        res_out.branch_target = btgt;
      end
      OP_BNE: begin
        res_out.take_branch   = (a != b);
        res_out.branch_target = btgt;
      end
      OP_BGTZ: begin
        res_out.take_branch   = !a[31] && (a != 32'd0);
        res_out.branch_target = btgt;
      end
      OP_J: begin
        res_out.take_branch   = 1'b1;
        res_out.branch_target = jtgt;
      end
      OP_JAL: begin
        res_out.take_branch   = 1'b1;
        res_out.branch_target = jtgt;
        res_out.exec_value    = pc4;
        res_out.reg_write     = 1'b1;
        res_out.write_reg     = LINK_REG;
      end
      default: res_out = '0;
    endcase
  end

endmodule

// ----- hw/rtl/mips_decode_execute_unit.sv -----
// Decode and execute unit for a MIPS32 subset with NAND and NORI. Each
// transaction carries one instruction word with its resolved rs and rt values
// and its PC, and yields one result transaction: ALU value, register write,
// memory access kind, store data, branch decision and target, and halt.
// A transaction is accepted into the input register; its result is then loaded
// into the result register through the combinational decode and execute logic
// once that register is empty or out_stall is low; one transaction is
// accepted every cycle while out_stall is low. Unknown opcodes and functions
// give an all-zero result.
// Depends on mdeu_pkg and mdeu_core.
module mips_decode_execute_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mdeu_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mdeu_pkg::out_t  out_data
);
  import mdeu_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  in_t   s1_data_r;
  logic  out_valid_r;
  logic  out_valid_nxt;
  out_t  out_data_r;
  out_t  core_res;
  logic  s1_adv;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  mdeu_core u_core (
    .op_in   (s1_data_r),
    .res_out (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted transaction not held in input register");

  a_s1_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("advancing transaction lost before result register");

  a_no_write_no_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.reg_write) |-> (out_data_r.write_reg == 5'd0))
    else $error("destination given without register write");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.halt) |->
      (!out_data_r.reg_write && out_data_r.mem_kind == MK_NONE &&
       !out_data_r.take_branch))
    else $error("halt result carries side effects");

endmodule
